>>> hw/rtl/imh_pkg.sv
package imh_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_BITS_DEF = 32;

   typedef enum logic [2:0] {
      KIND_INSERT   = 3'd0,
      KIND_EXTRACT  = 3'd1,
      KIND_DECREASE = 3'd2,
      KIND_LOAD     = 3'd3,
      KIND_BUILD    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      SA_ONE, SA_CNT, SA_NEW, SA_PAR, SA_L, SA_R, SA_S, SA_M, SA_BI, SA_P
   } slot_sel_type;

   typedef enum logic [1:0] {WD_REQ, WD_CAND, WD_ELEM} wd_sel_type;
   typedef enum logic [1:0] {IA_EID, IA_CID, IA_REQ, IA_NEW} ia_sel_type;
   typedef enum logic [1:0] {IW_RD, IW_TA, IW_NEW} iw_sel_type;
   typedef enum logic [2:0] {SS_HOLD, SS_NEW, SS_ONE, SS_M, SS_P, SS_BI} s_sel_type;
   typedef enum logic [2:0] {MS_HOLD, MS_SELF, MS_PAR, MS_L, MS_R, MS_CNT} m_sel_type;
   typedef enum logic [1:0] {CS_HOLD, CS_ELEM, CS_RD} c_sel_type;
   typedef enum logic [2:0] {ES_HOLD, ES_RD, ES_CAND, ES_REQ, ES_NEW} e_sel_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_type;
   typedef enum logic [1:0] {BI_HOLD, BI_LOAD, BI_DEC} bi_op_type;

   typedef struct packed {
      logic         latch_req;
      slot_sel_type slot_sel;
      logic         key_we;
      logic         id_we;
      wd_sel_type   wd_sel;
      ia_sel_type   ia_sel;
      logic         is_we;
      iw_sel_type   iw_sel;
      logic         ld_ta;
      s_sel_type    s_sel;
      m_sel_type    m_sel;
      c_sel_type    c_sel;
      e_sel_type    e_sel;
      cnt_op_type   cnt_op;
      bi_op_type    bi_op;
      logic         set_status;
      status_type   status_val;
      logic         set_handle;
      logic         ld_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     cnt_zero;
      logic     cnt_full;
      logic     s_is_one;
      logic     l_ok;
      logic     r_ok;
      logic     rd_gt_e;
      logic     rd_lt_c;
      logic     m_eq_s;
      logic     id_bad;
      logic     p_bad;
      logic     sid_ne;
      logic     key_gt;
      logic     bi_zero;
   } stat_type;

endpackage

>>> hw/rtl/indexed_min_heap.sv
// Channel   Ports                                       Handshake
// request   req_kind, req_key, req_item_id              start high while busy low
// response  rsp_status, rsp_handle, rsp_min_key,        rsp_valid, one cycle per word
//           rsp_min_id, rsp_count
//
// One word is handled at a time; busy is high from the accepting edge until the result shows,
// and the next word can be accepted in the cycle that shows the result. A build runs count/2
// sift-downs. Reset empties the heap at once; the memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_min_heap #(
   parameter  int CAPACITY = imh_pkg::CAPACITY_DEF,
   parameter  int KEY_BITS = imh_pkg::KEY_BITS_DEF,
   localparam int CB       = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_kind,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [CB-1:0]       req_item_id,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [CB-1:0]       rsp_handle,
   output logic [KEY_BITS-1:0] rsp_min_key,
   output logic [CB-1:0]       rsp_min_id,
   output logic [CB-1:0]       rsp_count
);

   imh_pkg::cmd_type  cmd;
   imh_pkg::stat_type stat;

   imh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   imh_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req_kind),
      .req_key     (req_key),
      .req_item_id (req_item_id),
      .rsp_status  (rsp_status),
      .rsp_handle  (rsp_handle),
      .rsp_min_key (rsp_min_key),
      .rsp_min_id  (rsp_min_id),
      .rsp_count   (rsp_count)
   );

endmodule

>>> hw/rtl/imh_ctrl.sv
module imh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  imh_pkg::stat_type stat,
   output imh_pkg::cmd_type  cmd
);

   typedef enum logic [24:0] {
      S_IDLE = 25'h0000001,
      S_DEC  = 25'h0000002,
      S_INS  = 25'h0000004,
      S_EX0  = 25'h0000008,
      S_EX1  = 25'h0000010,
      S_EX2  = 25'h0000020,
      S_DK0  = 25'h0000040,
      S_DK1  = 25'h0000080,
      S_DK2  = 25'h0000100,
      S_UP0  = 25'h0000200,
      S_UP1  = 25'h0000400,
      S_DN0  = 25'h0000800,
      S_DN1  = 25'h0001000,
      S_DN2  = 25'h0002000,
      S_DN3  = 25'h0004000,
      S_SW0  = 25'h0008000,
      S_SW1  = 25'h0010000,
      S_SW2  = 25'h0020000,
      S_SW3  = 25'h0040000,
      S_BL0  = 25'h0080000,
      S_BL1  = 25'h0100000,
      S_BL2  = 25'h0200000,
      S_FN0  = 25'h0400000,
      S_FN1  = 25'h0800000,
      S_SPR  = 25'h1000000
   } state_type;

   typedef enum logic [3:0] {
      M_UP   = 4'b0001,
      M_DOWN = 4'b0010,
      M_BLD  = 4'b0100,
      M_EXT  = 4'b1000
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DEC;
            end
         end
         S_DEC: begin
            case (stat.kind)
               imh_pkg::KIND_INSERT, imh_pkg::KIND_LOAD: begin
                  if (stat.cnt_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = imh_pkg::ST_RANGE;
                     state_in       = S_FN0;
                  end else begin
                     state_in = S_INS;
                  end
               end
               imh_pkg::KIND_EXTRACT:  state_in = S_EX0;
               imh_pkg::KIND_DECREASE: state_in = S_DK0;
               imh_pkg::KIND_BUILD:    state_in = S_BL0;
               default:                state_in = S_FN0;
            endcase
         end
         S_INS: begin
            cmd.slot_sel   = imh_pkg::SA_NEW;
            cmd.key_we     = 1'b1;
            cmd.id_we      = 1'b1;
            cmd.wd_sel     = imh_pkg::WD_REQ;
            cmd.ia_sel     = imh_pkg::IA_NEW;
            cmd.is_we      = 1'b1;
            cmd.iw_sel     = imh_pkg::IW_NEW;
            cmd.set_handle = 1'b1;
            cmd.s_sel      = imh_pkg::SS_NEW;
            cmd.e_sel      = imh_pkg::ES_NEW;
            cmd.cnt_op     = imh_pkg::CNT_INC;
            if (stat.kind == imh_pkg::KIND_INSERT) begin
               mode_in  = M_UP;
               state_in = S_UP0;
            end else begin
               state_in = S_FN0;
            end
         end
         S_EX0: begin
            if (stat.cnt_zero) begin
               cmd.set_status = 1'b1;
               cmd.status_val = imh_pkg::ST_RANGE;
               state_in       = S_FN0;
            end else begin
               cmd.slot_sel = imh_pkg::SA_ONE;
               cmd.s_sel    = imh_pkg::SS_ONE;
               state_in     = S_EX1;
            end
         end
         S_EX1: begin
            cmd.e_sel    = imh_pkg::ES_RD;
            cmd.slot_sel = imh_pkg::SA_CNT;
            cmd.m_sel    = imh_pkg::MS_CNT;
            state_in     = S_EX2;
         end
         S_EX2: begin
            cmd.c_sel = imh_pkg::CS_RD;
            mode_in   = M_EXT;
            state_in  = S_SW0;
         end
         S_DK0: begin
            if (stat.id_bad) begin
               cmd.set_status = 1'b1;
               cmd.status_val = imh_pkg::ST_ABSENT;
               state_in       = S_FN0;
            end else begin
               cmd.ia_sel = imh_pkg::IA_REQ;
               state_in   = S_DK1;
            end
         end
         S_DK1: begin
            if (stat.p_bad) begin
               cmd.set_status = 1'b1;
               cmd.status_val = imh_pkg::ST_ABSENT;
               state_in       = S_FN0;
            end else begin
               cmd.slot_sel = imh_pkg::SA_P;
               cmd.s_sel    = imh_pkg::SS_P;
               state_in     = S_DK2;
            end
         end
         S_DK2: begin
            if (stat.sid_ne) begin
               cmd.set_status = 1'b1;
               cmd.status_val = imh_pkg::ST_ABSENT;
               state_in       = S_FN0;
            end else if (stat.key_gt) begin
               state_in = S_FN0;
            end else begin
               cmd.slot_sel = imh_pkg::SA_S;
               cmd.key_we   = 1'b1;
               cmd.wd_sel   = imh_pkg::WD_REQ;
               cmd.e_sel    = imh_pkg::ES_REQ;
               mode_in      = M_UP;
               state_in     = S_UP0;
            end
         end
         S_UP0: begin
            if (stat.s_is_one) begin
               state_in = S_FN0;
            end else begin
               cmd.slot_sel = imh_pkg::SA_PAR;
               state_in     = S_UP1;
            end
         end
         S_UP1: begin
            if (stat.rd_gt_e) begin
               cmd.m_sel = imh_pkg::MS_PAR;
               cmd.c_sel = imh_pkg::CS_RD;
               state_in  = S_SW0;
            end else begin
               state_in = S_FN0;
            end
         end
         S_DN0: begin
            if (!stat.l_ok) begin
               if (mode_ff == M_BLD) begin
                  cmd.bi_op = imh_pkg::BI_DEC;
                  state_in  = S_BL1;
               end else begin
                  state_in = S_FN0;
               end
            end else begin
               cmd.m_sel    = imh_pkg::MS_SELF;
               cmd.c_sel    = imh_pkg::CS_ELEM;
               cmd.slot_sel = imh_pkg::SA_L;
               state_in     = S_DN1;
            end
         end
         S_DN1: begin
            if (stat.rd_lt_c) begin
               cmd.m_sel = imh_pkg::MS_L;
               cmd.c_sel = imh_pkg::CS_RD;
            end
            cmd.slot_sel = imh_pkg::SA_R;
            state_in     = S_DN2;
         end
         S_DN2: begin
            if (stat.r_ok && stat.rd_lt_c) begin
               cmd.m_sel = imh_pkg::MS_R;
               cmd.c_sel = imh_pkg::CS_RD;
            end
            state_in = S_DN3;
         end
         S_DN3: begin
            if (!stat.m_eq_s) begin
               state_in = S_SW0;
            end else if (mode_ff == M_BLD) begin
               cmd.bi_op = imh_pkg::BI_DEC;
               state_in  = S_BL1;
            end else begin
               state_in = S_FN0;
            end
         end
         S_SW0: begin
            cmd.slot_sel = imh_pkg::SA_S;
            cmd.key_we   = 1'b1;
            cmd.id_we    = 1'b1;
            cmd.wd_sel   = imh_pkg::WD_CAND;
            cmd.ia_sel   = imh_pkg::IA_EID;
            state_in     = S_SW1;
         end
         S_SW1: begin
            cmd.slot_sel = imh_pkg::SA_M;
            cmd.key_we   = 1'b1;
            cmd.id_we    = 1'b1;
            cmd.wd_sel   = imh_pkg::WD_ELEM;
            cmd.ia_sel   = imh_pkg::IA_CID;
            cmd.ld_ta    = 1'b1;
            state_in     = S_SW2;
         end
         S_SW2: begin
            cmd.ia_sel = imh_pkg::IA_EID;
            cmd.is_we  = 1'b1;
            cmd.iw_sel = imh_pkg::IW_RD;
            state_in   = S_SW3;
         end
         S_SW3: begin
            cmd.ia_sel = imh_pkg::IA_CID;
            cmd.is_we  = 1'b1;
            cmd.iw_sel = imh_pkg::IW_TA;
            case (mode_ff)
               M_EXT: begin
                  cmd.cnt_op = imh_pkg::CNT_DEC;
                  cmd.e_sel  = imh_pkg::ES_CAND;
                  mode_in    = M_DOWN;
                  state_in   = S_DN0;
               end
               M_UP: begin
                  cmd.s_sel = imh_pkg::SS_M;
                  state_in  = S_UP0;
               end
               default: begin
                  cmd.s_sel = imh_pkg::SS_M;
                  state_in  = S_DN0;
               end
            endcase
         end
         S_BL0: begin
            cmd.bi_op = imh_pkg::BI_LOAD;
            mode_in   = M_BLD;
            state_in  = S_BL1;
         end
         S_BL1: begin
            if (stat.bi_zero) begin
               state_in = S_FN0;
            end else begin
               cmd.slot_sel = imh_pkg::SA_BI;
               cmd.s_sel    = imh_pkg::SS_BI;
               state_in     = S_BL2;
            end
         end
         S_BL2: begin
            cmd.e_sel = imh_pkg::ES_RD;
            state_in  = S_DN0;
         end
         S_FN0: begin
            cmd.slot_sel = imh_pkg::SA_ONE;
            state_in     = S_FN1;
         end
         S_FN1: begin
            cmd.ld_rsp   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> hw/rtl/imh_datapath.sv
module imh_datapath #(
   parameter  int CAPACITY = imh_pkg::CAPACITY_DEF,
   parameter  int KEY_BITS = imh_pkg::KEY_BITS_DEF,
   localparam int CB       = $clog2(CAPACITY + 1),
   localparam int AW       = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                reset,
   input  imh_pkg::cmd_type    cmd,
   output imh_pkg::stat_type   stat,
   input  logic [2:0]          req_kind,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [CB-1:0]       req_item_id,
   output logic [1:0]          rsp_status,
   output logic [CB-1:0]       rsp_handle,
   output logic [KEY_BITS-1:0] rsp_min_key,
   output logic [CB-1:0]       rsp_min_id,
   output logic [CB-1:0]       rsp_count
);

   logic [KEY_BITS-1:0] slot_key_ff [CAPACITY];
   logic [CB-1:0]       slot_id_ff  [CAPACITY];
   logic [CB-1:0]       id_slot_ff  [CAPACITY];

   logic [KEY_BITS-1:0] key_rd_ff;
   logic [CB-1:0]       id_rd_ff, is_rd_ff;

   imh_pkg::kind_type   kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in, ek_ff, ek_in, ck_ff, ck_in;
   logic [CB-1:0]       id_ff, id_in, eid_ff, eid_in, cid_ff, cid_in;
   logic [CB-1:0]       cnt_ff, cnt_in, s_ff, s_in, m_ff, m_in, bi_ff, bi_in;
   logic [CB-1:0]       ta_ff, ta_in, handle_ff, handle_in;
   logic [1:0]          status_ff, status_in;

   logic [1:0]          rsp_status_ff;
   logic [CB-1:0]       rsp_handle_ff, rsp_min_id_ff, rsp_count_ff;
   logic [KEY_BITS-1:0] rsp_min_key_ff;

   logic [CB:0]         cnt_new, slot_l, slot_r, slot_val;
   logic [CB-1:0]       id_val, is_wdata, slot_par;
   logic [AW-1:0]       slot_idx, id_idx;
   logic [KEY_BITS-1:0] key_wdata;
   logic [CB-1:0]       sid_wdata;

   assign cnt_new  = {1'b0, cnt_ff} + 1'b1;
   assign slot_l   = {s_ff, 1'b0};
   assign slot_r   = {s_ff, 1'b1};
   assign slot_par = s_ff >> 1;

   always_comb begin
      case (cmd.slot_sel)
         imh_pkg::SA_ONE: slot_val = (CB+1)'(1);
         imh_pkg::SA_CNT: slot_val = {1'b0, cnt_ff};
         imh_pkg::SA_NEW: slot_val = cnt_new;
         imh_pkg::SA_PAR: slot_val = {1'b0, slot_par};
         imh_pkg::SA_L:   slot_val = slot_l;
         imh_pkg::SA_R:   slot_val = slot_r;
         imh_pkg::SA_S:   slot_val = {1'b0, s_ff};
         imh_pkg::SA_M:   slot_val = {1'b0, m_ff};
         imh_pkg::SA_BI:  slot_val = {1'b0, bi_ff};
         imh_pkg::SA_P:   slot_val = {1'b0, is_rd_ff};
         default:         slot_val = (CB+1)'(1);
      endcase
      case (cmd.ia_sel)
         imh_pkg::IA_EID: id_val = eid_ff;
         imh_pkg::IA_CID: id_val = cid_ff;
         imh_pkg::IA_REQ: id_val = id_ff;
         default:         id_val = cnt_new[CB-1:0];
      endcase
      case (cmd.wd_sel)
         imh_pkg::WD_CAND: begin
            key_wdata = ck_ff;
            sid_wdata = cid_ff;
         end
         imh_pkg::WD_ELEM: begin
            key_wdata = ek_ff;
            sid_wdata = eid_ff;
         end
         default: begin
            key_wdata = key_ff;
            sid_wdata = cnt_new[CB-1:0];
         end
      endcase
      case (cmd.iw_sel)
         imh_pkg::IW_RD: is_wdata = is_rd_ff;
         imh_pkg::IW_TA: is_wdata = ta_ff;
         default:        is_wdata = cnt_new[CB-1:0];
      endcase
   end

   assign slot_idx = AW'(slot_val - 1'b1);
   assign id_idx   = AW'(id_val - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         slot_key_ff[slot_idx] <= key_wdata;
      end
      key_rd_ff <= slot_key_ff[slot_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.id_we) begin
         slot_id_ff[slot_idx] <= sid_wdata;
      end
      id_rd_ff <= slot_id_ff[slot_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.is_we) begin
         id_slot_ff[id_idx] <= is_wdata;
      end
      is_rd_ff <= id_slot_ff[id_idx];
   end

   always_comb begin
      kind_in   = kind_ff;
      key_in    = key_ff;
      id_in     = id_ff;
      status_in = status_ff;
      handle_in = handle_ff;
      cnt_in    = cnt_ff;
      s_in      = s_ff;
      m_in      = m_ff;
      ck_in     = ck_ff;
      cid_in    = cid_ff;
      ek_in     = ek_ff;
      eid_in    = eid_ff;
      bi_in     = bi_ff;
      ta_in     = cmd.ld_ta ? is_rd_ff : ta_ff;

      if (cmd.latch_req) begin
         kind_in   = imh_pkg::kind_type'(req_kind);
         key_in    = req_key;
         id_in     = req_item_id;
         status_in = imh_pkg::ST_OK;
         handle_in = '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_val;
      end
      if (cmd.set_handle) begin
         handle_in = cnt_new[CB-1:0];
      end

      case (cmd.cnt_op)
         imh_pkg::CNT_INC: cnt_in = cnt_new[CB-1:0];
         imh_pkg::CNT_DEC: cnt_in = cnt_ff - 1'b1;
         default:          cnt_in = cnt_ff;
      endcase

      case (cmd.s_sel)
         imh_pkg::SS_NEW: s_in = cnt_new[CB-1:0];
         imh_pkg::SS_ONE: s_in = CB'(1);
         imh_pkg::SS_M:   s_in = m_ff;
         imh_pkg::SS_P:   s_in = is_rd_ff;
         imh_pkg::SS_BI:  s_in = bi_ff;
         default:         s_in = s_ff;
      endcase

      case (cmd.m_sel)
         imh_pkg::MS_SELF: m_in = s_ff;
         imh_pkg::MS_PAR:  m_in = slot_par;
         imh_pkg::MS_L:    m_in = slot_l[CB-1:0];
         imh_pkg::MS_R:    m_in = slot_r[CB-1:0];
         imh_pkg::MS_CNT:  m_in = cnt_ff;
         default:          m_in = m_ff;
      endcase

      case (cmd.c_sel)
         imh_pkg::CS_ELEM: begin
            ck_in  = ek_ff;
            cid_in = eid_ff;
         end
         imh_pkg::CS_RD: begin
            ck_in  = key_rd_ff;
            cid_in = id_rd_ff;
         end
         default: begin
            ck_in  = ck_ff;
            cid_in = cid_ff;
         end
      endcase

      case (cmd.e_sel)
         imh_pkg::ES_RD: begin
            ek_in  = key_rd_ff;
            eid_in = id_rd_ff;
         end
         imh_pkg::ES_CAND: begin
            ek_in  = ck_ff;
            eid_in = cid_ff;
         end
         imh_pkg::ES_REQ: begin
            ek_in  = key_ff;
            eid_in = id_ff;
         end
         imh_pkg::ES_NEW: begin
            ek_in  = key_ff;
            eid_in = cnt_new[CB-1:0];
         end
         default: begin
            ek_in  = ek_ff;
            eid_in = eid_ff;
         end
      endcase

      case (cmd.bi_op)
         imh_pkg::BI_LOAD: bi_in = cnt_ff >> 1;
         imh_pkg::BI_DEC:  bi_in = bi_ff - 1'b1;
         default:          bi_in = bi_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      id_ff     <= id_in;
      status_ff <= status_in;
      handle_ff <= handle_in;
      s_ff      <= s_in;
      m_ff      <= m_in;
      ck_ff     <= ck_in;
      cid_ff    <= cid_in;
      ek_ff     <= ek_in;
      eid_ff    <= eid_in;
      bi_ff     <= bi_in;
      ta_ff     <= ta_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_handle_ff  <= handle_ff;
         rsp_count_ff   <= cnt_ff;
         rsp_min_key_ff <= (cnt_ff == '0) ? '0 : key_rd_ff;
         rsp_min_id_ff  <= (cnt_ff == '0) ? '0 : id_rd_ff;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_handle  = rsp_handle_ff;
   assign rsp_min_key = rsp_min_key_ff;
   assign rsp_min_id  = rsp_min_id_ff;
   assign rsp_count   = rsp_count_ff;

   always_comb begin
      stat.kind     = kind_ff;
      stat.cnt_zero = (cnt_ff == '0);
      stat.cnt_full = (cnt_ff == CB'(CAPACITY));
      stat.s_is_one = (s_ff == CB'(1));
      stat.l_ok     = (slot_l <= {1'b0, cnt_ff});
      stat.r_ok     = (slot_r <= {1'b0, cnt_ff});
      stat.rd_gt_e  = (key_rd_ff > ek_ff);
      stat.rd_lt_c  = (key_rd_ff < ck_ff);
      stat.m_eq_s   = (m_ff == s_ff);
      stat.id_bad   = (id_ff == '0) || (id_ff > CB'(CAPACITY));
      stat.p_bad    = (is_rd_ff == '0) || (is_rd_ff > cnt_ff);
      stat.sid_ne   = (id_rd_ff != id_ff);
      stat.key_gt   = (key_ff > key_rd_ff);
      stat.bi_zero  = (bi_ff == '0);
   end

endmodule

>>> hw/rtl/imh_checker.sv
module imh_checker #(
   parameter  int CAPACITY = imh_pkg::CAPACITY_DEF,
   parameter  int KEY_BITS = imh_pkg::KEY_BITS_DEF,
   localparam int CB       = $clog2(CAPACITY + 1)
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [2:0]          req_kind,
   input logic [KEY_BITS-1:0] req_key,
   input logic [CB-1:0]       req_item_id,
   input logic                rsp_valid,
   input logic [1:0]          rsp_status,
   input logic [CB-1:0]       rsp_handle,
   input logic [KEY_BITS-1:0] rsp_min_key,
   input logic [CB-1:0]       rsp_min_id,
   input logic [CB-1:0]       rsp_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CB'(CAPACITY))
      else $error("count above capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_min_key == '0 && rsp_min_id == '0)
      else $error("empty heap reports a minimum");

   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handle != '0 |-> rsp_status == imh_pkg::ST_OK && rsp_handle == rsp_count)
      else $error("handle does not match the new count");

endmodule

bind indexed_min_heap imh_checker #(
   .CAPACITY (CAPACITY),
   .KEY_BITS (KEY_BITS)
) u_imh_checker (.*);
